### hdl/sams_pkg.sv
// Package for the shared-array multi-stack block: field widths, command and
// status codes, register indexes and the word types used on the ports.
// Depends on nothing; every other file imports it.
package sams_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int MAX_STACKS_DEF  = 8;

  localparam int VALUE_W      = 32;
  localparam int DEPTH_W      = 9;
  localparam int STACK_W      = 3;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;
  localparam int STACKS_REG_W = 4;
  localparam int CAP_REG_W    = 9;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STACKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [STACK_W-1:0]        stack_index;
    logic signed [VALUE_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [DEPTH_W-1:0]        depth_count;
  } out_word_t;

  typedef struct packed {
    logic               inc;
    logic               dec;
    logic [STACK_W-1:0] stack;
  } dir_upd_t;

endpackage

### hdl/sams_store.sv
// Slot store: one synchronous memory, one write port and one read port with
// registered read data. Depends on sams_pkg.
module sams_store #(
  parameter int STORE_DEPTH = sams_pkg::STORE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(STORE_DEPTH)-1:0]       wa,
  input  logic [sams_pkg::VALUE_W-1:0]         wd,
  input  logic [$clog2(STORE_DEPTH)-1:0]       ra,
  output logic [sams_pkg::VALUE_W-1:0]         rd
);
  import sams_pkg::*;

  logic [VALUE_W-1:0] mem_r [STORE_DEPTH];
  logic [VALUE_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_r <= mem_r[ra];
  end

  assign rd = rd_r;

endmodule

### hdl/sams_dir.sv
// Stack directory: configuration registers, base offsets, lengths and the
// total of used slots. Depends on sams_pkg.
module sams_dir #(
  parameter int STORE_DEPTH = sams_pkg::STORE_DEPTH_DEF,
  parameter int MAX_STACKS  = sams_pkg::MAX_STACKS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [sams_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sams_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  sams_pkg::dir_upd_t                    upd,
  input  logic [sams_pkg::STACK_W-1:0]          sel_stack,
  output logic [sams_pkg::STACKS_REG_W-1:0]     stacks_in_use,
  output logic [sams_pkg::CAP_REG_W-1:0]        capacity,
  output logic [$clog2(STORE_DEPTH+1)-1:0]      base_sel,
  output logic [$clog2(STORE_DEPTH+1)-1:0]      len_sel,
  output logic [$clog2(STORE_DEPTH+1)-1:0]      used
);
  import sams_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam logic [STACKS_REG_W-1:0] STACKS_RST =
    STACKS_REG_W'((MAX_STACKS < 8) ? MAX_STACKS : 8);
  localparam logic [CAP_REG_W-1:0] CAP_RST =
    CAP_REG_W'((STORE_DEPTH < 256) ? STORE_DEPTH : 256);

  logic [STACKS_REG_W-1:0] stacks_r;
  logic [CAP_REG_W-1:0]    cap_r;
  logic [CW-1:0]           base_r [MAX_STACKS];
  logic [CW-1:0]           len_r  [MAX_STACKS];
  logic [CW-1:0]           used_r;
  logic [STACKS_REG_W-1:0] stk_wr;
  logic [CAP_REG_W-1:0]    cap_wr;
  logic [SW-1:0]           sel;

  always_comb begin
    stk_wr = cfg_data[STACKS_REG_W-1:0];
    if (stk_wr == '0) begin
      stk_wr = STACKS_REG_W'(1);
    end else if (int'(stk_wr) > MAX_STACKS) begin
      stk_wr = STACKS_REG_W'(MAX_STACKS);
    end
    cap_wr = cfg_data[CAP_REG_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CAP_REG_W'(1);
    end else if (int'(cap_wr) > STORE_DEPTH) begin
      cap_wr = CAP_REG_W'(STORE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stacks_r <= STACKS_RST;
      cap_r    <= CAP_RST;
      used_r   <= '0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        base_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_STACKS) begin
        stacks_r <= stk_wr;
      end
      if (cfg_index == REG_CAPACITY) begin
        cap_r <= cap_wr;
      end
      used_r <= '0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        base_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else if (upd.inc || upd.dec) begin
      used_r <= upd.inc ? CW'(used_r + 1'b1) : CW'(used_r - 1'b1);
      for (int i = 0; i < MAX_STACKS; i++) begin
        if (i > int'(upd.stack)) begin
          base_r[i] <= upd.inc ? CW'(base_r[i] + 1'b1) : CW'(base_r[i] - 1'b1);
        end
        if (i == int'(upd.stack)) begin
          len_r[i] <= upd.inc ? CW'(len_r[i] + 1'b1) : CW'(len_r[i] - 1'b1);
        end
      end
    end
  end

  assign sel           = SW'(sel_stack);
  assign base_sel      = base_r[sel];
  assign len_sel       = len_r[sel];
  assign used          = used_r;
  assign stacks_in_use = stacks_r;
  assign capacity      = cap_r;

endmodule

### hdl/sams_seq.sv
// Command sequencer: decodes a command, sweeps the slot store one element a
// cycle to open or close a gap, and registers the result. Depends on sams_pkg.
module sams_seq #(
  parameter int STORE_DEPTH = sams_pkg::STORE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  sams_pkg::in_word_t                    in_word,
  output logic                                  out_valid,
  output sams_pkg::out_word_t                   out_word,
  input  logic [sams_pkg::STACKS_REG_W-1:0]     stacks_in_use,
  input  logic [sams_pkg::CAP_REG_W-1:0]        capacity,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]      base_sel,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]      len_sel,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]      used,
  output sams_pkg::dir_upd_t                    upd,
  output logic                                  mem_we,
  output logic [$clog2(STORE_DEPTH)-1:0]        mem_wa,
  output logic [sams_pkg::VALUE_W-1:0]          mem_wd,
  output logic [$clog2(STORE_DEPTH)-1:0]        mem_ra,
  input  logic [sams_pkg::VALUE_W-1:0]          mem_rd
);
  import sams_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_PUSH_MV, S_RD_LAST, S_POP_MV} state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      ra_r, ra_nxt;
  logic [AW-1:0]      prev_r, prev_nxt;
  logic [AW-1:0]      end_r, end_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic               wpend_r, wpend_nxt;
  logic               first_r, first_nxt;
  logic               pop_r, pop_nxt;
  logic [STACK_W-1:0] stk_r, stk_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               invalid;
  logic               full;
  logic               empty;
  logic [CW-1:0]      end_c;
  logic [CW-1:0]      moves;

  assign invalid = {1'b0, in_word.stack_index} >= stacks_in_use;
  assign full    = used >= CW'(capacity);
  assign empty   = len_sel == '0;
  assign end_c   = CW'(base_sel + len_sel);
  assign moves   = CW'(used - end_c);

  always_comb begin
    state_nxt     = state_r;
    ra_nxt        = ra_r;
    prev_nxt      = prev_r;
    end_nxt       = end_r;
    left_nxt      = left_r;
    wpend_nxt     = wpend_r;
    first_nxt     = first_r;
    pop_nxt       = pop_r;
    stk_nxt       = stk_r;
    val_nxt       = val_r;
    depth_nxt     = depth_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_wa        = prev_r;
    mem_wd        = mem_rd;
    mem_ra        = ra_r;
    upd           = '0;
    upd.stack     = stk_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          stk_nxt      = in_word.stack_index;
          out_word_nxt = '0;
          if (invalid) begin
            out_valid_nxt       = 1'b1;
            out_word_nxt.status = ST_INVALID;
          end else begin
            case (in_word.command)
              CMD_PUSH: begin
                if (full) begin
                  out_valid_nxt            = 1'b1;
                  out_word_nxt.status      = ST_OVERFLOW;
                  out_word_nxt.depth_count = DEPTH_W'(len_sel);
                end else begin
                  state_nxt = S_PUSH_MV;
                  ra_nxt    = AW'(used - 1'b1);
                  left_nxt  = moves;
                  wpend_nxt = 1'b0;
                  end_nxt   = AW'(end_c);
                  val_nxt   = in_word.push_value;
                  depth_nxt = DEPTH_W'(len_sel + 1'b1);
                end
              end
              CMD_POP, CMD_PEEK: begin
                if (empty) begin
                  out_valid_nxt       = 1'b1;
                  out_word_nxt.status = ST_UNDERFLOW;
                end else begin
                  state_nxt = S_RD_LAST;
                  ra_nxt    = AW'(end_c - 1'b1);
                  pop_nxt   = in_word.command == CMD_POP;
                  left_nxt  = (in_word.command == CMD_POP) ? moves : '0;
                  depth_nxt = (in_word.command == CMD_POP) ?
                              DEPTH_W'(len_sel - 1'b1) : DEPTH_W'(len_sel);
                end
              end
              CMD_COUNT: begin
                out_valid_nxt = 1'b1;
                if (empty) begin
                  out_word_nxt.status = ST_UNDERFLOW;
                end else begin
                  out_word_nxt.status      = ST_OK;
                  out_word_nxt.depth_count = DEPTH_W'(len_sel);
                end
              end
              default: begin
                out_valid_nxt = 1'b0;
              end
            endcase
          end
        end
      end
      S_PUSH_MV: begin
        if (left_r != '0) begin
          ra_nxt   = AW'(ra_r - 1'b1);
          left_nxt = CW'(left_r - 1'b1);
          prev_nxt = ra_r;
        end
        wpend_nxt = left_r != '0;
        if (wpend_r) begin
          mem_we = 1'b1;
          mem_wa = AW'(prev_r + 1'b1);
          mem_wd = mem_rd;
        end else if (left_r == '0) begin
          mem_we                   = 1'b1;
          mem_wa                   = end_r;
          mem_wd                   = val_r;
          upd.inc                  = 1'b1;
          out_valid_nxt            = 1'b1;
          out_word_nxt             = '0;
          out_word_nxt.status      = ST_OK;
          out_word_nxt.depth_count = depth_r;
          state_nxt                = S_IDLE;
        end
      end
      S_RD_LAST: begin
        ra_nxt    = AW'(ra_r + 1'b1);
        first_nxt = 1'b1;
        wpend_nxt = 1'b0;
        state_nxt = S_POP_MV;
      end
      S_POP_MV: begin
        first_nxt = 1'b0;
        if (first_r) begin
          val_nxt = mem_rd;
        end
        if (left_r != '0) begin
          ra_nxt   = AW'(ra_r + 1'b1);
          left_nxt = CW'(left_r - 1'b1);
          prev_nxt = ra_r;
        end
        wpend_nxt = left_r != '0;
        if (wpend_r) begin
          mem_we = 1'b1;
          mem_wa = AW'(prev_r - 1'b1);
          mem_wd = mem_rd;
        end else if (left_r == '0) begin
          upd.dec                  = pop_r;
          out_valid_nxt            = 1'b1;
          out_word_nxt.read_value  = first_r ? mem_rd : val_r;
          out_word_nxt.status      = ST_OK;
          out_word_nxt.depth_count = depth_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wpend_r     <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wpend_r     <= wpend_nxt;
      first_r     <= first_nxt;
    end
    ra_r       <= ra_nxt;
    prev_r     <= prev_nxt;
    end_r      <= end_nxt;
    left_r     <= left_nxt;
    pop_r      <= pop_nxt;
    stk_r      <= stk_nxt;
    val_r      <= val_nxt;
    depth_r    <= depth_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### hdl/shared_array_multi_stack.sv
// Top level of the shared-array multi-stack block: directory, sequencer and
// slot store. Depends on sams_pkg, sams_dir, sams_seq and sams_store.
//
//   channel   ports                                  transfer
//   input     start, busy, in_word                   start high while busy low
//   result    out_valid, out_word                    one cycle, cannot be held off
//   config    cfg_valid, cfg_ready, cfg_index/data   valid and ready high
//
// Count, an invalid stack, overflow and underflow leave busy low and give their
// result in the next cycle. A push, pop or peek raises busy; a push or pop shifts
// the n words stored above the addressed stack's top (up to 255) by one slot, up
// or down, and a peek moves none. The store's single write port moves one word a
// cycle. The result appears in the same cycle that busy falls.
// Reset is synchronous and empties every stack; the store needs no clearing.
module shared_array_multi_stack #(
  parameter int STORE_DEPTH = sams_pkg::STORE_DEPTH_DEF,
  parameter int MAX_STACKS  = sams_pkg::MAX_STACKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  sams_pkg::in_word_t                in_word,
  output logic                              out_valid,
  output sams_pkg::out_word_t               out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sams_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sams_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sams_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);

  logic [STACKS_REG_W-1:0] stacks_in_use;
  logic [CAP_REG_W-1:0]    capacity;
  logic [CW-1:0]           base_sel;
  logic [CW-1:0]           len_sel;
  logic [CW-1:0]           used;
  dir_upd_t                upd;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [AW-1:0]           mem_ra;
  logic [VALUE_W-1:0]      mem_wd;
  logic [VALUE_W-1:0]      mem_rd;

  assign cfg_ready = !busy;

  sams_dir #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_STACKS  (MAX_STACKS)
  ) u_dir (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .upd           (upd),
    .sel_stack     (in_word.stack_index),
    .stacks_in_use (stacks_in_use),
    .capacity      (capacity),
    .base_sel      (base_sel),
    .len_sel       (len_sel),
    .used          (used)
  );

  sams_seq #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_word      (out_word),
    .stacks_in_use (stacks_in_use),
    .capacity      (capacity),
    .base_sel      (base_sel),
    .len_sel       (len_sel),
    .used          (used),
    .upd           (upd),
    .mem_we        (mem_we),
    .mem_wa        (mem_wa),
    .mem_wd        (mem_wd),
    .mem_ra        (mem_ra),
    .mem_rd        (mem_rd)
  );

  sams_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

endmodule

### hdl/sams_chk.sv
// Port-level checker for shared_array_multi_stack, bound to the top level.
// Depends on sams_pkg and on the top level's port names.
module sams_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input sams_pkg::out_word_t out_word
);
  import sams_pkg::*;

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a command behind it");

  a_busy_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("long command finished without a result word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == ST_INVALID) |->
      (out_word.read_value == '0 && out_word.depth_count == '0))
    else $error("invalid-stack result carries data");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == ST_UNDERFLOW) |->
      (out_word.read_value == '0 && out_word.depth_count == '0))
    else $error("underflow result carries data");

endmodule

bind shared_array_multi_stack sams_chk u_sams_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

### tb/shared_array_multi_stack_tb.sv
// Self-checking testbench for shared_array_multi_stack: drives command words and
// register writes, predicts every reply word and compares it field by field.
// Depends on sams_pkg and the RTL of the block; reads no files.
module shared_array_multi_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sams_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PRINT_LIMIT  = 40;

  class stack_tracker;
    logic [VALUE_W-1:0] slot_mem[STORE_DEPTH_DEF];
    logic [DEPTH_W-1:0] base_of[MAX_STACKS_DEF];
    logic [DEPTH_W-1:0] len_of[MAX_STACKS_DEF];
    int n_stacks;
    int capacity;
    out_word_t due_replies[$];
    int errors;
    int commands;
    int status_seen[4];

    function new();
      n_stacks = MAX_STACKS_DEF;
      capacity = STORE_DEPTH_DEF;
      errors = 0;
      commands = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
      clear_stacks();
    endfunction

    function void clear_stacks();
      foreach (base_of[k]) begin
        base_of[k] = '0;
        len_of[k] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int v;
      if (idx == REG_STACKS) begin
        v = data[STACKS_REG_W-1:0];
        n_stacks = (v < 1) ? 1 : (v > MAX_STACKS_DEF) ? MAX_STACKS_DEF : v;
      end else begin
        v = data[CAP_REG_W-1:0];
        capacity = (v < 1) ? 1 : (v > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : v;
      end
      clear_stacks();
    endfunction

    function void note_command(in_word_t w);
      out_word_t e;
      int s;
      int used;
      int top;
      e = '0;
      s = w.stack_index;
      used = base_of[n_stacks-1] + len_of[n_stacks-1];
      commands++;
      if (s >= n_stacks) begin
        e.status = ST_INVALID;
      end else if (w.command == CMD_PUSH) begin
        if (used >= capacity) begin
          e.status = ST_OVERFLOW;
          e.depth_count = len_of[s];
        end else begin
          top = base_of[s] + len_of[s];
          for (int i = used; i > top; i--) slot_mem[i] = slot_mem[i-1];
          slot_mem[top] = w.push_value;
          for (int i = s + 1; i < n_stacks; i++) base_of[i] = base_of[i] + 1'b1;
          len_of[s] = len_of[s] + 1'b1;
          e.depth_count = len_of[s];
        end
      end else if (len_of[s] == 0) begin
        e.status = ST_UNDERFLOW;
      end else begin
        top = base_of[s] + len_of[s];
        if (w.command != CMD_COUNT) e.read_value = slot_mem[top-1];
        if (w.command == CMD_POP) begin
          for (int i = top; i < used; i++) slot_mem[i-1] = slot_mem[i];
          for (int i = s + 1; i < n_stacks; i++) base_of[i] = base_of[i] - 1'b1;
          len_of[s] = len_of[s] - 1'b1;
        end
        e.depth_count = len_of[s];
      end
      status_seen[e.status]++;
      due_replies.push_back(e);
    endfunction

    task report_mismatch(string field, logic signed [VALUE_W-1:0] got,
                         logic signed [VALUE_W-1:0] want);
      if (errors < PRINT_LIMIT)
        $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
      errors++;
    endtask

    task check_reply(out_word_t r);
      out_word_t e;
      if (due_replies.size() == 0) begin
        report_mismatch("reply word with nothing due", r.read_value, 0);
        return;
      end
      e = due_replies.pop_front();
      if (r.read_value !== e.read_value) report_mismatch("read_value", r.read_value, e.read_value);
      if (r.status !== e.status) report_mismatch("status", r.status, e.status);
      if (r.depth_count !== e.depth_count)
        report_mismatch("depth_count", r.depth_count, e.depth_count);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_word = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int idle_pct = 18;
  int quiet_cycles = 0;
  stack_tracker tracker;

  shared_array_multi_stack DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_reply(out_word);
      if (start && !busy) tracker.note_command(in_word);
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, stopping", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int stack,
                          input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= in_word_t'{command: cmd, stack_index: stack[STACK_W-1:0], push_value: value};
    do @(posedge clk); while (busy);
  endtask

  // Registers are only written once every reply word has come back.
  task automatic configure(input logic [CFG_DATA_W-1:0] stacks_data,
                           input logic [CFG_DATA_W-1:0] cap_data);
    start <= 1'b0;
    @(posedge clk);
    while (tracker.due_replies.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_STACKS;
    cfg_data <= stacks_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_CAPACITY;
    cfg_data <= cap_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Alternates between filling and draining so that both full and empty stacks occur.
  task automatic run_phase(input int idle, input int stacks,
                           input logic [CFG_DATA_W-1:0] stacks_data,
                           input logic [CFG_DATA_W-1:0] cap_data, input int count);
    int fill_pct;
    int left_in_mode;
    int r;
    int stack;
    logic [CMD_W-1:0] cmd;
    logic [VALUE_W-1:0] value;
    configure(stacks_data, cap_data);
    idle_pct = idle;
    fill_pct = 80;
    left_in_mode = $urandom_range(60, 20);
    repeat (count) begin
      if (left_in_mode == 0) begin
        fill_pct = (fill_pct == 80) ? 15 : 80;
        left_in_mode = $urandom_range(60, 20);
      end
      left_in_mode--;
      r = $urandom_range(99);
      if (r < fill_pct) begin
        cmd = CMD_PUSH;
      end else if (r < fill_pct + (100 - fill_pct) * 6 / 10) begin
        cmd = CMD_POP;
      end else if ($urandom_range(1) == 0) begin
        cmd = CMD_PEEK;
      end else begin
        cmd = CMD_COUNT;
      end
      stack = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(stacks - 1);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = '0;
          default: value = '1;
        endcase
      end else begin
        value = $urandom();
      end
      send_cmd(cmd, stack, value);
    end
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // One stack of one slot: both registers saturate upward.
    configure(9'd0, 9'd0);
    send_cmd(CMD_COUNT, 0, '0);
    send_cmd(CMD_PUSH, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH, 0, 32'h0000_0001);
    send_cmd(CMD_PUSH, 1, 32'h5555_5555);
    send_cmd(CMD_PEEK, 7, '0);
    send_cmd(CMD_PEEK, 0, '1);
    send_cmd(CMD_POP, 0, '0);
    send_cmd(CMD_POP, 0, '0);
    send_cmd(CMD_PEEK, 0, '0);

    // Eight stacks over the whole store: both registers saturate downward.
    configure(9'h00F, 9'h1FF);
    send_cmd(CMD_PUSH, 7, 32'h8000_0000);
    send_cmd(CMD_PUSH, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH, 3, 32'h0000_0000);
    send_cmd(CMD_PUSH, 0, 32'h1234_5678);
    send_cmd(CMD_COUNT, 7, '0);
    send_cmd(CMD_PEEK, 7, '0);
    send_cmd(CMD_POP, 0, '0);
    send_cmd(CMD_POP, 3, '0);
    send_cmd(CMD_COUNT, 3, '0);
    send_cmd(CMD_COUNT, 0, '0);

    // Three stacks sharing four slots, filled to overflow.
    configure(9'd3, 9'd4);
    send_cmd(CMD_PUSH, 2, 32'hA5A5_A5A5);
    send_cmd(CMD_PUSH, 0, 32'h0F0F_0F0F);
    send_cmd(CMD_PUSH, 1, 32'hDEAD_BEEF);
    send_cmd(CMD_PUSH, 1, 32'h0000_0002);
    send_cmd(CMD_PUSH, 0, 32'h0000_0003);
    send_cmd(CMD_PUSH, 7, 32'h0000_0004);
    send_cmd(CMD_POP, 1, '0);
    send_cmd(CMD_PEEK, 1, '0);

    run_phase(18, 8, 9'd8, 9'd40, 300);
    run_phase(76, 2, 9'h1F2, 9'd256, 250);
    run_phase(0, 1, 9'd1, 9'd9, 100);
    run_phase(0, 7, 9'd7, 9'd17, 270);

    start <= 1'b0;
    @(posedge clk);
    while (tracker.due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d ok, %0d invalid stack, %0d overflow, %0d underflow",
             tracker.commands, tracker.status_seen[ST_OK], tracker.status_seen[ST_INVALID],
             tracker.status_seen[ST_OVERFLOW], tracker.status_seen[ST_UNDERFLOW]);
    $display("register settings ranged from 1 to 8 stacks and 1 to 256 slots, %0d mismatches",
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
